// ----- rtl/lcmt_pkg.sv -----
// ----------------------------------------------------------------------------
// lcmt_pkg
// Field widths, register indexes, command codes and sequencer types for the
// Li Chao line tree.
// ----------------------------------------------------------------------------
package lcmt_pkg;

  localparam int SLOPE_W    = 32;
  localparam int ICPT_W     = 57;
  localparam int VALUE_W    = 58;
  localparam int BASE_W     = 24;
  localparam int POINT_W    = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  // difference of two lines: slope, intercept and value
  localparam int DSL_W  = SLOPE_W + 1;
  localparam int DIC_W  = ICPT_W + 1;
  localparam int DIFF_W = VALUE_W + 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEEK_MAX    = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CLEAR = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_CHECK = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_ADD   = 7'b0100000,
    ST_EVAL  = 7'b1000000
  } state_t;

  // insert compares at the node midpoint, then the low end, then the high end
  typedef enum logic [1:0] {
    PH_MID = 2'd0,
    PH_LO  = 2'd1,
    PH_HI  = 2'd2
  } phase_t;

endpackage

// ----- rtl/li_chao_line_min_tree.sv -----
// ----------------------------------------------------------------------------
// li_chao_line_min_tree
// Li Chao tree of lines y = slope*x + intercept over 2^DOMAIN_BITS points,
// with a node memory and one shared multiply-add unit under a sequencer.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+----------------------
//  command   | cmd, slope, intercept, point              | start & !busy
//  result    | best_value, empty_res                     | done, one cycle
//  config    | cfg_index, cfg_wdata                      | cfg_we
//
//  After reset the node memory is cleared one entry a cycle, all 2^(DOMAIN_BITS+1)
//  entries (2048 by default), with busy high.
//  Each query walks DOMAIN_BITS+1 tree levels, an insert at most that many; a level
//  is one node memory read plus, per line compare, MUL, ADD, EVAL of the shared unit.
//  Query: an empty level is READ and CHECK; an occupied level adds MUL, ADD, EVAL.
//  Insert: per level, compares at mid, then low end, then high end.
//  done pulses for one cycle per query; the receiver cannot stall it.
//
module li_chao_line_min_tree #(
  parameter int DOMAIN_BITS = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   cmd,
  input  logic signed [lcmt_pkg::SLOPE_W-1:0]    slope,
  input  logic signed [lcmt_pkg::ICPT_W-1:0]     intercept,
  input  logic        [lcmt_pkg::POINT_W-1:0]    point,
  output logic                                   done,
  output logic signed [lcmt_pkg::VALUE_W-1:0]    best_value,
  output logic                                   empty_res,
  input  logic                                   cfg_we,
  input  logic        [lcmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [lcmt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lcmt_pkg::*;

  localparam int IDX_W = DOMAIN_BITS + 1;
  localparam int NODES = 2 ** IDX_W;
  localparam int XW    = ((BASE_W > DOMAIN_BITS + 1) ? BASE_W : DOMAIN_BITS + 1) + 1;
  localparam int MW    = 1 + SLOPE_W + ICPT_W;

  state_t state;
  phase_t phase;

  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       clr_cnt;
  logic [DOMAIN_BITS-1:0] lo;
  logic [DOMAIN_BITS-1:0] hi;
  logic [DOMAIN_BITS-1:0] off;
  logic [DOMAIN_BITS-1:0] mid;
  logic [DOMAIN_BITS-1:0] x_sel;
  logic [POINT_W+DOMAIN_BITS-1:0] pt_ext;
  logic                   is_query;

  logic signed [SLOPE_W-1:0] cur_slope;
  logic signed [ICPT_W-1:0]  cur_icpt;

  logic [MW-1:0]             node_mem [NODES];
  logic [MW-1:0]             rd_word;
  logic                      rd_valid;
  logic signed [SLOPE_W-1:0] rd_slope;
  logic signed [ICPT_W-1:0]  rd_icpt;

  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic [MW-1:0]             mem_wdata;

  logic signed [DSL_W-1:0]    dsl;
  logic signed [DIC_W-1:0]    dic;
  logic signed [XW-1:0]       x_reg;
  logic signed [XW-1:0]       x_next;
  logic signed [DSL_W+XW-1:0] prod_full;
  logic signed [DIFF_W-1:0]   prod;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [VALUE_W-1:0]  val;
  logic signed [VALUE_W-1:0]  acc;
  logic signed [VALUE_W-1:0]  acc_next;

  logic neg_flag;
  logic found;
  logic diff_pos;
  logic diff_neg;
  logic mover_better;
  logic val_better;
  logic at_leaf;
  logic go_left;

  logic signed [BASE_W-1:0] domain_base;
  logic                     seek_max;

  assign busy = (state != ST_IDLE);
  assign {rd_valid, rd_slope, rd_icpt} = rd_word;
  assign pt_ext = (POINT_W + DOMAIN_BITS)'(point);

  assign mid     = lo + ((hi - lo) >> 1);
  assign at_leaf = (lo == hi);
  assign go_left = (off <= mid);

  // compare results of the shared unit
  assign val        = diff[VALUE_W-1:0];
  assign val_better = seek_max ? (val > acc) : (val < acc);
  assign acc_next   = (!found || val_better) ? val : acc;
  assign diff_neg   = diff[DIFF_W-1];
  assign diff_pos   = !diff[DIFF_W-1] && (diff != '0);
  // after a swap the moving line is the old node line: the difference flips
  assign mover_better = (seek_max ^ neg_flag) ? diff_pos : diff_neg;

  assign prod_full = dsl * x_reg;
  assign x_next    = XW'(domain_base) + XW'($signed({1'b0, x_sel}));

  always_comb begin
    if (state == ST_CHECK) begin
      x_sel = is_query ? off : mid;
    end else if (phase == PH_MID) begin
      x_sel = lo;
    end else begin
      x_sel = hi;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = {1'b1, cur_slope, cur_icpt};
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (state == ST_CHECK && !is_query && !rd_valid) begin
      mem_we = 1'b1;
    end else if (state == ST_EVAL && !is_query && phase == PH_MID && mover_better) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    if (state == ST_READ) begin
      rd_word <= node_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      done        <= 1'b0;
      domain_base <= '0;
      seek_max    <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_DOMAIN_BASE: domain_base <= $signed(cfg_wdata[BASE_W-1:0]);
          REG_SEEK_MAX:    seek_max    <= cfg_wdata[0];
        endcase
      end

      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (start) begin
            is_query  <= (cmd == CMD_QUERY);
            cur_slope <= slope;
            cur_icpt  <= intercept;
            off       <= pt_ext[DOMAIN_BITS-1:0];
            idx       <= IDX_W'(1);
            lo        <= '0;
            hi        <= '1;
            found     <= 1'b0;
            acc       <= '0;
            state     <= ST_READ;
          end
        end

        ST_READ: begin
          state <= ST_CHECK;
        end

        ST_CHECK: begin
          if (is_query) begin
            if (rd_valid) begin
              dsl   <= DSL_W'(rd_slope);
              dic   <= DIC_W'(rd_icpt);
              x_reg <= x_next;
              state <= ST_MUL;
            end else if (at_leaf) begin
              best_value <= found ? acc : '0;
              empty_res  <= !found;
              done       <= 1'b1;
              state      <= ST_IDLE;
            end else begin
              if (go_left) begin
                hi  <= mid;
                idx <= {idx[IDX_W-2:0], 1'b0};
              end else begin
                lo  <= mid + 1'b1;
                idx <= {idx[IDX_W-2:0], 1'b1};
              end
              state <= ST_READ;
            end
          end else begin
            if (rd_valid) begin
              dsl      <= DSL_W'(cur_slope) - DSL_W'(rd_slope);
              dic      <= DIC_W'(cur_icpt) - DIC_W'(rd_icpt);
              x_reg    <= x_next;
              neg_flag <= 1'b0;
              phase    <= PH_MID;
              state    <= ST_MUL;
            end else begin
              // empty node takes the line
              state <= ST_IDLE;
            end
          end
        end

        ST_MUL: begin
          prod  <= DIFF_W'(prod_full);
          state <= ST_ADD;
        end

        ST_ADD: begin
          diff  <= prod + DIFF_W'(dic);
          state <= ST_EVAL;
        end

        ST_EVAL: begin
          if (is_query) begin
            acc   <= acc_next;
            found <= 1'b1;
            if (at_leaf) begin
              best_value <= acc_next;
              empty_res  <= 1'b0;
              done       <= 1'b1;
              state      <= ST_IDLE;
            end else begin
              if (go_left) begin
                hi  <= mid;
                idx <= {idx[IDX_W-2:0], 1'b0};
              end else begin
                lo  <= mid + 1'b1;
                idx <= {idx[IDX_W-2:0], 1'b1};
              end
              state <= ST_READ;
            end
          end else begin
            case (phase)
              PH_MID: begin
                if (mover_better) begin
                  // new line stays at the node, old one moves on
                  cur_slope <= rd_slope;
                  cur_icpt  <= rd_icpt;
                  neg_flag  <= 1'b1;
                end
                if (at_leaf) begin
                  state <= ST_IDLE;
                end else begin
                  x_reg <= x_next;
                  phase <= PH_LO;
                  state <= ST_MUL;
                end
              end
              PH_LO: begin
                if (mover_better) begin
                  hi    <= mid;
                  idx   <= {idx[IDX_W-2:0], 1'b0};
                  state <= ST_READ;
                end else begin
                  x_reg <= x_next;
                  phase <= PH_HI;
                  state <= ST_MUL;
                end
              end
              PH_HI: begin
                if (mover_better) begin
                  lo    <= mid + 1'b1;
                  idx   <= {idx[IDX_W-2:0], 1'b1};
                  state <= ST_READ;
                end else begin
                  // drop the line: it wins nowhere
                  state <= ST_IDLE;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_from_walk: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EVAL || state == ST_CHECK))
    else $error("result strobe without a finished walk");

  a_accept_reads_root: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_READ && idx == IDX_W'(1)))
    else $error("accepted item does not start at the root");

  a_read_index_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (idx != '0))
    else $error("node read at index zero");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && empty_res) |-> (best_value == '0))
    else $error("empty result carries a nonzero value");
`endif

endmodule
